/* rtl/ipc_mailbox_channel_table_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mailbox channel table
// Shared property forms; each use names clk and rst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef IPC_MAILBOX_CHANNEL_TABLE_TOP_ASSERT_SVH
`define IPC_MAILBOX_CHANNEL_TABLE_TOP_ASSERT_SVH

// Same-cycle implication
`define IPCMB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IPCMB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ipcmb_pkg.sv */
// ----------------------------------------------------------------------------
// ipcmb_pkg
// Types and constants shared by the mailbox channel table modules.
// ----------------------------------------------------------------------------
package ipcmb_pkg;

  localparam int DEF_SLOTS = 64;
  localparam int ID_W      = 64;
  localparam int MSG_W     = 64;

  // Request operation codes
  typedef enum logic [1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_SEND    = 2'd2,
    KIND_RECEIVE = 2'd3
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  // One slot of the channel table
  typedef struct packed {
    logic            in_use;
    logic            full;
    logic [ID_W-1:0] id;
  } entry_t;

  // Write enables toward the slot store
  typedef struct packed {
    logic ent_we;
    logic msg_we;
  } wr_ctl_t;

endpackage

/* rtl/ipcmb_store.sv */
// ----------------------------------------------------------------------------
// ipcmb_store
// Slot entry and message memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ipcmb_store #(
  parameter int SLOTS = ipcmb_pkg::DEF_SLOTS,
  parameter int IDXW  = 6
) (
  input  logic                        clk,
  input  ipcmb_pkg::wr_ctl_t          wr,
  input  logic [IDXW-1:0]             wr_addr,
  input  ipcmb_pkg::entry_t           wr_entry,
  input  logic [ipcmb_pkg::MSG_W-1:0] wr_msg,
  input  logic                        rd_en,
  input  logic [IDXW-1:0]             rd_addr,
  output ipcmb_pkg::entry_t           rd_entry,
  output logic [ipcmb_pkg::MSG_W-1:0] rd_msg
);
  import ipcmb_pkg::*;

  entry_t           ent_mem [SLOTS];
  logic [MSG_W-1:0] msg_mem [SLOTS];
  entry_t           rd_entry_r;
  logic [MSG_W-1:0] rd_msg_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.ent_we) begin
      ent_mem[wr_addr] <= wr_entry;
    end
    if (wr.msg_we) begin
      msg_mem[wr_addr] <= wr_msg;
    end
  end

  // Registered read port, both memories at one address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= ent_mem[rd_addr];
      rd_msg_r   <= msg_mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_msg   = rd_msg_r;

endmodule

/* rtl/ipc_mailbox_channel_table_top.sv */
// A transfer starts a scan that reads slot 0 upward and tests each slot read; a hit, or
// the end of the table on a miss or a full table, ends it. One request at a time.
// The scan reads one slot per cycle through the single read port of the slot memory,
// and no new request is taken until the result has been loaded into the output register.
// Reset: a clearing pass writes every slot empty, with in_tready low.
// ----------------------------------------------------------------------------
// ipc_mailbox_channel_table_top
// Table of one-message mailboxes: create, destroy, send and receive requests
// served by a sequential scan with one shared id compare.
// ----------------------------------------------------------------------------
`include "ipc_mailbox_channel_table_top_assert.svh"

module ipc_mailbox_channel_table_top #(
  parameter int SLOTS = ipcmb_pkg::DEF_SLOTS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] channel_id, [127:64] message
  input  logic [1:0]   in_tuser,   // [1:0] kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] new_channel, [127:64] received
  output logic [0:0]   out_tuser   // [0] status
);
  import ipcmb_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [IDXW-1:0]  chk_idx_r, chk_idx_nxt;
  logic [ID_W-1:0]  id_counter_r, id_counter_nxt;
  kind_t            req_kind_r, req_kind_nxt;
  logic [ID_W-1:0]  req_chan_r, req_chan_nxt;
  logic [MSG_W-1:0] req_msg_r, req_msg_nxt;
  logic             res_status_r, res_status_nxt;
  logic [ID_W-1:0]  res_new_r, res_new_nxt;
  logic [MSG_W-1:0] res_rcv_r, res_rcv_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [ID_W-1:0]  out_new_r, out_new_nxt;
  logic [MSG_W-1:0] out_rcv_r, out_rcv_nxt;

  wr_ctl_t          wr;
  logic [IDXW-1:0]  wr_addr;
  entry_t           wr_entry;
  logic             rd_en;
  logic [IDXW-1:0]  rd_addr;
  entry_t           rd_entry;
  logic [MSG_W-1:0] rd_msg;
  logic             hit;
  logic [ID_W-1:0]  id_next;
  logic             out_load;

  ipcmb_store #(
    .SLOTS (SLOTS),
    .IDXW  (IDXW)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .wr_msg   (req_msg_r),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_msg   (rd_msg)
  );

  // Shared slot test: free slot for create, active id match otherwise
  assign id_next = id_counter_r + 64'd1;
  assign hit = (req_kind_r == KIND_CREATE) ? !rd_entry.in_use
             : (rd_entry.in_use && (rd_entry.id == req_chan_r));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    id_counter_nxt = id_counter_r;
    req_kind_nxt   = req_kind_r;
    req_chan_nxt   = req_chan_r;
    req_msg_nxt    = req_msg_r;
    res_status_nxt = res_status_r;
    res_new_nxt    = res_new_r;
    res_rcv_nxt    = res_rcv_r;
    wr             = '0;
    wr_addr        = chk_idx_r;
    wr_entry       = '0;
    rd_en          = 1'b0;
    rd_addr        = cnt_r[IDXW-1:0];
    in_tready      = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        wr.ent_we = 1'b1;
        wr_addr   = cnt_r[IDXW-1:0];
        if (cnt_r == CW'(SLOTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          req_kind_nxt = kind_t'(in_tuser);
          req_chan_nxt = in_tdata[63:0];
          req_msg_nxt  = in_tdata[127:64];
          cnt_nxt      = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // issue one read a cycle, test the slot read the cycle before
        rd_en       = (cnt_r != CW'(SLOTS));
        chk_vld_nxt = rd_en;
        chk_idx_nxt = cnt_r[IDXW-1:0];
        if (rd_en) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (chk_vld_r && hit) begin
          state_nxt      = ST_RESP;
          chk_vld_nxt    = 1'b0;
          res_status_nxt = 1'b1;
          res_new_nxt    = '0;
          res_rcv_nxt    = '0;
          case (req_kind_r)
            KIND_CREATE: begin
              wr.ent_we       = 1'b1;
              wr_entry.in_use = 1'b1;
              wr_entry.id     = id_next;
              id_counter_nxt  = id_next;
              res_status_nxt  = 1'b0;
              res_new_nxt     = id_next;
            end
            KIND_DESTROY: begin
              wr.ent_we      = 1'b1;
              res_status_nxt = 1'b0;
            end
            KIND_SEND: begin
              if (!rd_entry.full) begin
                wr.ent_we       = 1'b1;
                wr.msg_we       = 1'b1;
                wr_entry.in_use = 1'b1;
                wr_entry.full   = 1'b1;
                wr_entry.id     = req_chan_r;
                res_status_nxt  = 1'b0;
              end
            end
            KIND_RECEIVE: begin
              if (rd_entry.full) begin
                wr.ent_we       = 1'b1;
                wr_entry.in_use = 1'b1;
                wr_entry.id     = req_chan_r;
                res_status_nxt  = 1'b0;
                res_rcv_nxt     = rd_msg;
              end
            end
            default: begin
              res_status_nxt = 1'b1;
            end
          endcase
        end else if (!chk_vld_r && (cnt_r == CW'(SLOTS))) begin
          // no slot found: table full or unknown channel
          state_nxt      = ST_RESP;
          res_status_nxt = 1'b1;
          res_new_nxt    = '0;
          res_rcv_nxt    = '0;
        end
      end
      ST_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_status_nxt = out_status_r;
    out_new_nxt    = out_new_r;
    out_rcv_nxt    = out_rcv_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
      out_status_nxt = res_status_r;
      out_new_nxt    = res_new_r;
      out_rcv_nxt    = res_rcv_r;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      cnt_r        <= '0;
      chk_vld_r    <= 1'b0;
      id_counter_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      chk_vld_r    <= chk_vld_nxt;
      id_counter_r <= id_counter_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    req_kind_r   <= req_kind_nxt;
    req_chan_r   <= req_chan_nxt;
    req_msg_r    <= req_msg_nxt;
    res_status_r <= res_status_nxt;
    res_new_r    <= res_new_nxt;
    res_rcv_r    <= res_rcv_nxt;
    out_status_r <= out_status_nxt;
    out_new_r    <= out_new_nxt;
    out_rcv_r    <= out_rcv_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_rcv_r, out_new_r};
  assign out_tuser  = out_status_r;

  // Checks
  `IPCMB_ASSERT_NXT(a_accept_scan, in_tvalid && in_tready, state_r == ST_SCAN, "transfer did not start a scan")
  `IPCMB_ASSERT_IMP(a_err_zero, out_tvalid_r && out_status_r, (out_new_r == '0) && (out_rcv_r == '0), "error result carries data")
  `IPCMB_ASSERT_IMP(a_wr_state, wr.ent_we || wr.msg_we, state_r == ST_CLEAR || state_r == ST_SCAN, "table write outside clear or scan")
  `IPCMB_ASSERT_IMP(a_msg_send, wr.msg_we, (req_kind_r == KIND_SEND) && !rd_entry.full, "message write without send to empty mailbox")

endmodule

/* bench/ipc_mailbox_channel_table_tb.sv */
// ----------------------------------------------------------------------------
// Mailbox channel table testbench
// Drives create, destroy, send and receive requests into the channel table.
// A scoreboard keeps its own copy of the slots and the id counter and predicts
// each result. Traffic opens and closes channels in phases, so the table fills
// and drains. Both stream ports idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import ipcmb_pkg::*;

  localparam int SLOTS        = DEF_SLOTS;
  localparam int DIRECTED_MAX = 25;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASE_LEN    = 150;
  localparam int LIMIT_CYCLES = 1_000_000;

  // Traffic mixes for the random part
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} traffic_mix_t;

  // One predicted response
  typedef struct packed {
    logic             status;
    logic [ID_W-1:0]  new_channel;
    logic [MSG_W-1:0] received;
  } mailbox_result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // [63:0] channel_id, [127:64] message
  logic [1:0]   in_tuser;   // [1:0] kind
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // [63:0] new_channel, [127:64] received
  logic [0:0]   out_tuser;  // [0] status

  // --------------------------------------------------------------------------
  // Scoreboard: shadow channel table and queue of pending responses
  // --------------------------------------------------------------------------
  class mailbox_scoreboard;
    logic [ID_W-1:0]  chan_id   [SLOTS];
    logic [MSG_W-1:0] chan_msg  [SLOTS];
    bit               chan_full [SLOTS];
    bit               chan_open [SLOTS];
    logic [ID_W-1:0]  last_id;
    logic [ID_W-1:0]  closed_ids[$];
    mailbox_result_t  pending[$];
    int errors;
    int n_requests, n_responses, peak_open;
    int n_create_ok, n_table_full, n_destroy_ok, n_send_ok, n_send_full;
    int n_recv_ok, n_recv_empty, n_no_channel;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        chan_id[i]   = '0;
        chan_msg[i]  = '0;
        chan_full[i] = 1'b0;
        chan_open[i] = 1'b0;
      end
      last_id = '0;
    endfunction

    // lowest open slot carrying this id, SLOTS when none
    function int find_channel(logic [ID_W-1:0] id);
      for (int i = 0; i < SLOTS; i++)
        if (chan_open[i] && chan_id[i] == id) return i;
      return SLOTS;
    endfunction

    function int open_count();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) n += chan_open[i];
      return n;
    endfunction

    // id of a random open channel; caller checks open_count first
    function logic [ID_W-1:0] any_open_channel();
      int pick;
      pick = $urandom_range(0, open_count() - 1);
      for (int i = 0; i < SLOTS; i++) begin
        if (chan_open[i]) begin
          if (pick == 0) return chan_id[i];
          pick--;
        end
      end
      return '0;
    endfunction

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Accepted request: update the shadow table and queue the response
    function void note_request(kind_t kind, logic [ID_W-1:0] chan, logic [MSG_W-1:0] msg);
      mailbox_result_t r;
      int slot;
      r = '{status: 1'b1, new_channel: '0, received: '0};
      n_requests++;
      if (kind == KIND_CREATE) begin
        slot = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!chan_open[i]) slot = i;
        if (slot < SLOTS) begin
          last_id         = last_id + 1'b1;
          chan_id[slot]   = last_id;
          chan_msg[slot]  = '0;
          chan_full[slot] = 1'b0;
          chan_open[slot] = 1'b1;
          r.new_channel   = last_id;
          r.status        = 1'b0;
          n_create_ok++;
        end else begin
          n_table_full++;
        end
      end else begin
        slot = find_channel(chan);
        if (slot == SLOTS) begin
          n_no_channel++;
        end else if (kind == KIND_DESTROY) begin
          chan_open[slot] = 1'b0;
          chan_id[slot]   = '0;
          chan_full[slot] = 1'b0;
          r.status        = 1'b0;
          closed_ids.push_back(chan);
          if (closed_ids.size() > 8) void'(closed_ids.pop_front());
          n_destroy_ok++;
        end else if (kind == KIND_SEND) begin
          if (!chan_full[slot]) begin
            chan_msg[slot]  = msg;
            chan_full[slot] = 1'b1;
            r.status        = 1'b0;
            n_send_ok++;
          end else begin
            n_send_full++;
          end
        end else begin
          if (chan_full[slot]) begin
            r.received      = chan_msg[slot];
            chan_full[slot] = 1'b0;
            r.status        = 1'b0;
            n_recv_ok++;
          end else begin
            n_recv_empty++;
          end
        end
      end
      if (open_count() > peak_open) peak_open = open_count();
      pending.push_back(r);
    endfunction

    // Accepted response: compare field by field with the oldest prediction
    task check_result(logic status, logic [ID_W-1:0] new_chan, logic [MSG_W-1:0] got);
      mailbox_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("response with none outstanding (status %0d)", status));
        return;
      end
      exp_r = pending.pop_front();
      n_responses++;
      if (status !== exp_r.status)
        report($sformatf("response %0d status %0d, predicted %0d",
                         n_responses, status, exp_r.status));
      if (new_chan !== exp_r.new_channel)
        report($sformatf("response %0d new_channel %h, predicted %h",
                         n_responses, new_chan, exp_r.new_channel));
      if (got !== exp_r.received)
        report($sformatf("response %0d received %h, predicted %h",
                         n_responses, got, exp_r.received));
    endtask
  endclass

  mailbox_scoreboard sb;
  longint unsigned cycle_count;

  ipc_mailbox_channel_table_top #(.SLOTS(SLOTS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // Monitor: sample both transfers at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser[0], out_tdata[63:0], out_tdata[127:64]);
      if (in_tvalid && in_tready)
        sb.note_request(kind_t'(in_tuser), in_tdata[63:0], in_tdata[127:64]);
    end
  end

  // Receiver backpressure in randomly picked stall modes
  initial begin
    int mode;
    int tick;
    mode       = 0;
    tick       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (tick % 128 == 0) mode = $urandom_range(0, 3);
      tick++;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((tick % 8) < 3);
      endcase
    end
  end

  // One request transfer; entered and left at a falling edge
  task send_request(kind_t kind, logic [ID_W-1:0] chan, logic [MSG_W-1:0] msg);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {msg, chan};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Gap between bursts; a zero-length gap leaves valid asserted
  task idle_sender(int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Random request shaped by the current mix; ids mostly name open channels
  task make_request(traffic_mix_t mix, output kind_t kind, output logic [ID_W-1:0] chan,
                    output logic [MSG_W-1:0] msg);
    int r;
    int w_create, w_destroy, w_send;
    case (mix)
      MIX_FILL:  begin w_create = 60; w_destroy = 5;  w_send = 20; end
      MIX_DRAIN: begin w_create = 5;  w_destroy = 45; w_send = 25; end
      default:   begin w_create = 20; w_destroy = 15; w_send = 35; end
    endcase
    r = $urandom_range(0, 99);
    if (r < w_create)                         kind = KIND_CREATE;
    else if (r < w_create + w_destroy)          kind = KIND_DESTROY;
    else if (r < w_create + w_destroy + w_send) kind = KIND_SEND;
    else                                        kind = KIND_RECEIVE;

    r = $urandom_range(0, 99);
    if (r < 78 && sb.open_count() > 0)
      chan = sb.any_open_channel();
    else if (r < 86 && sb.closed_ids.size() > 0)
      chan = sb.closed_ids[$urandom_range(0, sb.closed_ids.size() - 1)];
    else if (r < 93)
      chan = {$urandom, $urandom};
    else
      chan = sb.last_id + $urandom_range(1, 3);  // not given out yet

    r = $urandom_range(0, 9);
    if (r == 0)      msg = '0;
    else if (r == 1) msg = '1;
    else             msg = {$urandom, $urandom};
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    kind_t            kind;
    logic [ID_W-1:0]  chan;
    logic [MSG_W-1:0] msg;
    traffic_mix_t     mix;
    int               sent, burst, phase;

    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_CREATE;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: misses on an empty table, full and empty mailboxes,
    // extreme ids and messages, destroy with a message held, slot reuse
    send_request(KIND_RECEIVE, 64'd0, '1);
    send_request(KIND_DESTROY, '1, '0);
    send_request(KIND_SEND, 64'd1, '1);
    send_request(KIND_CREATE, '1, '1);               // id 1
    send_request(KIND_CREATE, '0, '0);               // id 2
    send_request(KIND_RECEIVE, 64'd1, '0);           // empty mailbox
    send_request(KIND_SEND, 64'd1, '1);
    send_request(KIND_SEND, 64'd1, '0);              // full, first message kept
    send_request(KIND_RECEIVE, 64'd1, '0);
    send_request(KIND_SEND, 64'd2, '0);              // zero message is valid
    send_request(KIND_RECEIVE, 64'd2, '1);
    send_request(KIND_SEND, 64'd2, 64'h5555_5555_5555_5555);
    send_request(KIND_DESTROY, 64'd2, '0);           // stale word never readable
    send_request(KIND_RECEIVE, 64'd2, '0);
    send_request(KIND_SEND, 64'd2, '1);
    send_request(KIND_DESTROY, 64'd2, '0);
    send_request(KIND_CREATE, 64'hAAAA_AAAA_AAAA_AAAA, '0);  // id 3 in freed slot
    send_request(KIND_RECEIVE, 64'd3, '0);           // message cleared on create
    send_request(KIND_SEND, 64'd1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(KIND_DESTROY, 64'd1, '0);           // closed while holding a message
    send_request(KIND_SEND, 64'h8000_0000_0000_0000, '1);
    send_request(KIND_RECEIVE, 64'd5, '0);           // id ahead of the counter
    send_request(KIND_CREATE, '0, '0);               // id 4 in lowest slot
    idle_sender(3);

    // Random: phases fill the table past full, drain it, then mix at random
    sent  = 0;
    phase = -1;
    mix   = MIX_FILL;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        if (sent / PHASE_LEN != phase) begin
          phase = sent / PHASE_LEN;
          case (phase)
            0, 2:    mix = MIX_FILL;
            1, 3:    mix = MIX_DRAIN;
            default: mix = traffic_mix_t'($urandom_range(0, 2));
          endcase
        end
        make_request(mix, kind, chan, msg);
        send_request(kind, chan, msg);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) idle_sender(0);
      else                           idle_sender($urandom_range(1, 12));
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain, then watch for stray responses
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d responses never arrived", sb.pending.size()));

    $display("%0d requests, %0d responses; opened %0d, closed %0d, table full %0d times,"
             , sb.n_requests, sb.n_responses, sb.n_create_ok, sb.n_destroy_ok,
             sb.n_table_full);
    $display("sent %0d, mailbox full %0d, received %0d, empty %0d, unknown id %0d, peak %0d open",
             sb.n_send_ok, sb.n_send_full, sb.n_recv_ok, sb.n_recv_empty,
             sb.n_no_channel, sb.peak_open);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ipcmb_pkg.sv
rtl/ipcmb_store.sv
rtl/ipc_mailbox_channel_table_top.sv
bench/ipc_mailbox_channel_table_tb.sv
